### hw/rtl/json_byte_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef JSON_BYTE_TOKENIZER_MACROS_SVH
`define JSON_BYTE_TOKENIZER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define JBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Condition implies consequence in the next cycle.
`define JBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

### hw/rtl/jbt_pkg.sv
// Package: types, constants and word tables of the JSON byte tokenizer.
`default_nettype none
package jbt_pkg;

   localparam int MAX_BUFFER = 4096;
   localparam int OFF_W      = $clog2(MAX_BUFFER + 1);
   localparam int START_MAX  = 4095;
   localparam int LEN_MAX    = 4096;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_STR      = 4'd1,
      MODE_STR_ESC  = 4'd2,
      MODE_NUM_INT  = 4'd3,
      MODE_NUM_FRAC = 4'd4,
      MODE_NUM_EXPS = 4'd5,
      MODE_NUM_EXP  = 4'd6,
      MODE_LIT      = 4'd7,
      MODE_ERR      = 4'd8
   } mode_type;

   typedef enum logic [3:0] {
      TK_LBRACE = 4'd0,
      TK_RBRACE = 4'd1,
      TK_LBRACK = 4'd2,
      TK_RBRACK = 4'd3,
      TK_COLON  = 4'd4,
      TK_COMMA  = 4'd5,
      TK_STRING = 4'd6,
      TK_NUMBER = 4'd7,
      TK_TRUE   = 4'd8,
      TK_FALSE  = 4'd9,
      TK_NULL   = 4'd10,
      TK_END    = 4'd11,
      TK_ERROR  = 4'd12
   } tk_type;

   typedef enum logic [1:0] {
      WORD_TRUE  = 2'd0,
      WORD_FALSE = 2'd1,
      WORD_NULL  = 2'd2
   } word_type;

   typedef struct packed {
      tk_type      kind;
      logic [11:0] start;
      logic [12:0] len;
   } tok_type;

   // What the first byte of a token does.
   typedef struct packed {
      logic       emit;
      tk_type     kind;
      mode_type   mode;
      logic       lit;
      word_type   word;
      logic       set_begin;
      logic       begin_plus1;
   } start_res_type;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;

   function automatic logic [2:0] word_len(input word_type w);
      logic [2:0] r;
      case (w)
         WORD_FALSE: r = 3'd5;
         default:    r = 3'd4;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] word_char(input word_type w, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (w)
         WORD_FALSE: begin
            case (idx)
               3'd0:    r = 8'h66;
               3'd1:    r = 8'h61;
               3'd2:    r = 8'h6C;
               3'd3:    r = 8'h73;
               3'd4:    r = 8'h65;
               default: r = 8'h00;
            endcase
         end
         WORD_NULL: begin
            case (idx)
               3'd0:    r = 8'h6E;
               3'd1:    r = 8'h75;
               3'd2:    r = 8'h6C;
               3'd3:    r = 8'h6C;
               default: r = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    r = 8'h74;
               3'd1:    r = 8'h72;
               3'd2:    r = 8'h75;
               3'd3:    r = 8'h65;
               default: r = 8'h00;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic logic [11:0] sat_start(input logic [OFF_W-1:0] v);
      logic [11:0] r;
      if (32'(v) > START_MAX) r = 12'(START_MAX);
      else r = 12'(v);
      return r;
   endfunction

   function automatic logic [12:0] sat_len(input logic [OFF_W-1:0] v);
      logic [12:0] r;
      if (32'(v) > LEN_MAX) r = 13'(LEN_MAX);
      else r = 13'(v);
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/jbt_req_if.sv
// Interface: byte input channel of the tokenizer.
`default_nettype none
interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] input_byte;
   logic       last_byte;

   modport source (output valid, output input_byte, output last_byte, input ready);
   modport sink   (input valid, input input_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### hw/rtl/jbt_rsp_if.sv
// Interface: token output channel of the tokenizer.
`default_nettype none
interface jbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [11:0] token_start;
   logic [12:0] token_length;
   logic        run_last;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output run_last, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input run_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/json_byte_tokenizer.sv
// Latency: the first token of a byte is shown in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte makes at most one token and the output
// is taken; after a byte that makes more, input waits until the three-entry token buffer holds one.
// Reset (synchronous): lexer back to idle, offset zero, token buffer empty.
// Top level: streaming JSON tokenizer, one byte per item.
`default_nettype none
`include "json_byte_tokenizer_macros.svh"
module json_byte_tokenizer (
   input  wire        clock,
   input  wire        reset,
   jbt_req_if.sink    req,
   jbt_rsp_if.source  rsp
);

   // lexer state
   jbt_pkg::mode_type            mode_ff, mode_in;
   jbt_pkg::word_type            word_ff, word_in;
   logic [2:0]                   idx_ff, idx_in;
   logic [jbt_pkg::OFF_W-1:0]    off_ff, off_in;
   logic [jbt_pkg::OFF_W-1:0]    begin_ff, begin_in;

   // token buffer, slot 0 is shown
   jbt_pkg::tok_type             slot_ff [3];
   jbt_pkg::tok_type             slot_in [3];
   logic [1:0]                   cnt_ff, cnt_in;

   jbt_pkg::tok_type             cand [4];
   logic [3:0]                   cand_v;
   jbt_pkg::tok_type             new_slot [3];
   logic [1:0]                   new_cnt;

   logic fire, take;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= jbt_pkg::CH_0) && (b <= jbt_pkg::CH_9);
   endfunction

   function automatic jbt_pkg::start_res_type start_tok(input logic [7:0] b);
      jbt_pkg::start_res_type r;
      r = '0;
      r.mode = jbt_pkg::MODE_IDLE;
      r.kind = jbt_pkg::TK_ERROR;
      r.word = jbt_pkg::WORD_TRUE;
      case (b) inside
         jbt_pkg::CH_LBRACE: begin r.emit = 1'b1; r.kind = jbt_pkg::TK_LBRACE; end
         jbt_pkg::CH_RBRACE: begin r.emit = 1'b1; r.kind = jbt_pkg::TK_RBRACE; end
         jbt_pkg::CH_LBRACK: begin r.emit = 1'b1; r.kind = jbt_pkg::TK_LBRACK; end
         jbt_pkg::CH_RBRACK: begin r.emit = 1'b1; r.kind = jbt_pkg::TK_RBRACK; end
         jbt_pkg::CH_COLON:  begin r.emit = 1'b1; r.kind = jbt_pkg::TK_COLON; end
         jbt_pkg::CH_COMMA:  begin r.emit = 1'b1; r.kind = jbt_pkg::TK_COMMA; end
         jbt_pkg::CH_QUOTE: begin
            r.mode        = jbt_pkg::MODE_STR;
            r.set_begin   = 1'b1;
            r.begin_plus1 = 1'b1;
         end
         jbt_pkg::CH_T, jbt_pkg::CH_F, jbt_pkg::CH_N: begin
            r.mode      = jbt_pkg::MODE_LIT;
            r.lit       = 1'b1;
            r.set_begin = 1'b1;
            if (b == jbt_pkg::CH_T) r.word = jbt_pkg::WORD_TRUE;
            else if (b == jbt_pkg::CH_F) r.word = jbt_pkg::WORD_FALSE;
            else r.word = jbt_pkg::WORD_NULL;
         end
         jbt_pkg::CH_SPACE, [jbt_pkg::CH_TAB:jbt_pkg::CH_CR]: begin
         end
         jbt_pkg::CH_MINUS, [jbt_pkg::CH_0:jbt_pkg::CH_9]: begin
            r.mode      = jbt_pkg::MODE_NUM_INT;
            r.set_begin = 1'b1;
         end
         default: begin
            r.emit = 1'b1;
            r.kind = jbt_pkg::TK_ERROR;
            r.mode = jbt_pkg::MODE_ERR;
         end
      endcase
      return r;
   endfunction

   assign fire = req.valid && req.ready;
   assign take = rsp.valid && rsp.ready;

   // accept while the buffer is empty or drains its final token
   assign req.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);

   // lexer step for the byte at the input
   always_comb begin
      jbt_pkg::start_res_type  st;
      jbt_pkg::word_type       wk;
      logic [7:0]              b;
      logic                    num_end;
      logic                    do_start;
      logic [2:0]              wl;

      b        = req.input_byte;
      mode_in  = mode_ff;
      word_in  = word_ff;
      idx_in   = idx_ff;
      off_in   = off_ff;
      begin_in = begin_ff;
      num_end  = 1'b0;
      do_start = 1'b0;
      st       = '0;
      wk       = (word_ff == jbt_pkg::WORD_FALSE || word_ff == jbt_pkg::WORD_NULL) ?
                 word_ff : jbt_pkg::WORD_TRUE;
      wl       = jbt_pkg::word_len(wk);
      cand_v   = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end

      if (32'(off_ff) >= jbt_pkg::MAX_BUFFER) begin
         // past the buffer limit: one error, offset stays put
         if (mode_ff != jbt_pkg::MODE_ERR) begin
            cand_v[0]     = 1'b1;
            cand[0].kind  = jbt_pkg::TK_ERROR;
            cand[0].start = jbt_pkg::sat_start(off_ff);
            mode_in       = jbt_pkg::MODE_ERR;
         end
      end else begin
         off_in = off_ff + 1'b1;
         case (mode_ff)
            jbt_pkg::MODE_STR: begin
               if (b == jbt_pkg::CH_BSLASH) begin
                  mode_in = jbt_pkg::MODE_STR_ESC;
               end else if (b == jbt_pkg::CH_QUOTE) begin
                  cand_v[0]     = 1'b1;
                  cand[0].kind  = jbt_pkg::TK_STRING;
                  cand[0].start = jbt_pkg::sat_start(begin_ff);
                  cand[0].len   = jbt_pkg::sat_len(off_ff - begin_ff);
                  mode_in       = jbt_pkg::MODE_IDLE;
               end
            end
            jbt_pkg::MODE_STR_ESC: mode_in = jbt_pkg::MODE_STR;
            jbt_pkg::MODE_LIT: begin
               if (idx_ff < wl && b == jbt_pkg::word_char(wk, idx_ff)) begin
                  idx_in = idx_ff + 3'd1;
                  if (idx_in == wl) begin
                     cand_v[0]     = 1'b1;
                     cand[0].kind  = jbt_pkg::tk_type'(4'(jbt_pkg::TK_TRUE) + 4'(wk));
                     cand[0].start = jbt_pkg::sat_start(begin_ff);
                     cand[0].len   = 13'(wl);
                     mode_in       = jbt_pkg::MODE_IDLE;
                     idx_in        = 3'd0;
                  end
               end else begin
                  cand_v[0]     = 1'b1;
                  cand[0].kind  = jbt_pkg::TK_ERROR;
                  cand[0].start = jbt_pkg::sat_start(begin_ff);
                  mode_in       = jbt_pkg::MODE_ERR;
               end
            end
            jbt_pkg::MODE_ERR: begin
            end
            jbt_pkg::MODE_NUM_INT: begin
               if (is_digit(b)) begin
               end else if (b == jbt_pkg::CH_DOT) mode_in = jbt_pkg::MODE_NUM_FRAC;
               else if (b == jbt_pkg::CH_LO_E || b == jbt_pkg::CH_UP_E)
                  mode_in = jbt_pkg::MODE_NUM_EXPS;
               else num_end = 1'b1;
            end
            jbt_pkg::MODE_NUM_FRAC: begin
               if (is_digit(b)) begin
               end else if (b == jbt_pkg::CH_LO_E || b == jbt_pkg::CH_UP_E)
                  mode_in = jbt_pkg::MODE_NUM_EXPS;
               else num_end = 1'b1;
            end
            jbt_pkg::MODE_NUM_EXPS: begin
               if (is_digit(b) || b == jbt_pkg::CH_PLUS || b == jbt_pkg::CH_MINUS)
                  mode_in = jbt_pkg::MODE_NUM_EXP;
               else num_end = 1'b1;
            end
            jbt_pkg::MODE_NUM_EXP: begin
               if (!is_digit(b)) num_end = 1'b1;
            end
            default: do_start = 1'b1;
         endcase

         // a number closed by this byte; the byte then starts a token
         if (num_end) begin
            cand_v[0]     = 1'b1;
            cand[0].kind  = jbt_pkg::TK_NUMBER;
            cand[0].start = jbt_pkg::sat_start(begin_ff);
            cand[0].len   = jbt_pkg::sat_len(off_ff - begin_ff);
            do_start      = 1'b1;
         end

         if (do_start) begin
            st      = start_tok(b);
            mode_in = st.mode;
            if (st.emit) begin
               cand_v[1]     = 1'b1;
               cand[1].kind  = st.kind;
               cand[1].start = jbt_pkg::sat_start(off_ff);
            end
            if (st.lit) begin
               word_in = st.word;
               idx_in  = 3'd1;
            end
            if (st.set_begin) begin
               begin_in = off_ff + jbt_pkg::OFF_W'(st.begin_plus1);
            end
         end
      end

      if (req.last_byte) begin
         case (mode_in)
            jbt_pkg::MODE_STR, jbt_pkg::MODE_STR_ESC: begin
               cand_v[2]     = 1'b1;
               cand[2].kind  = jbt_pkg::TK_STRING;
               cand[2].start = jbt_pkg::sat_start(begin_in);
               cand[2].len   = jbt_pkg::sat_len(off_ff + 1'b1 - begin_in);
            end
            jbt_pkg::MODE_NUM_INT, jbt_pkg::MODE_NUM_FRAC,
            jbt_pkg::MODE_NUM_EXPS, jbt_pkg::MODE_NUM_EXP: begin
               cand_v[2]     = 1'b1;
               cand[2].kind  = jbt_pkg::TK_NUMBER;
               cand[2].start = jbt_pkg::sat_start(begin_in);
               cand[2].len   = jbt_pkg::sat_len(off_ff + 1'b1 - begin_in);
            end
            jbt_pkg::MODE_LIT: begin
               cand_v[2]     = 1'b1;
               cand[2].kind  = jbt_pkg::TK_ERROR;
               cand[2].start = jbt_pkg::sat_start(begin_in);
            end
            default: begin
            end
         endcase
         cand_v[3]     = 1'b1;
         cand[3].kind  = jbt_pkg::TK_END;
         cand[3].start = jbt_pkg::sat_start(off_ff);
         // buffer done: start the next one from scratch
         mode_in  = jbt_pkg::MODE_IDLE;
         word_in  = jbt_pkg::WORD_TRUE;
         idx_in   = 3'd0;
         off_in   = '0;
         begin_in = '0;
      end
   end

   // pack the candidates in order, at most three
   always_comb begin
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 3; i++) begin
         new_slot[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && n < 3'd3) begin
            new_slot[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      new_cnt = n[1:0];
   end

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
      if (fire) begin
         slot_in = new_slot;
         cnt_in  = new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jbt_pkg::MODE_IDLE;
         word_ff  <= jbt_pkg::WORD_TRUE;
         idx_ff   <= 3'd0;
         off_ff   <= '0;
         begin_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (fire) begin
            mode_ff  <= mode_in;
            word_ff  <= word_in;
            idx_ff   <= idx_in;
            off_ff   <= off_in;
            begin_ff <= begin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp.valid        = (cnt_ff != 2'd0);
   assign rsp.token_kind   = slot_ff[0].kind;
   assign rsp.token_start  = slot_ff[0].start;
   assign rsp.token_length = slot_ff[0].len;
   assign rsp.run_last     = (cnt_ff == 2'd1);

   `JBT_ASSERT_NOW(a_ready_only_when_draining, clock, reset,
      (cnt_ff != 2'd0 && cnt_ff != 2'd1), !req.ready)
   `JBT_ASSERT_NEXT(a_last_gives_token, clock, reset,
      (fire && req.last_byte), (cnt_ff != 2'd0))
   `JBT_ASSERT_NEXT(a_last_restarts, clock, reset,
      (fire && req.last_byte), (off_ff == '0 && mode_ff == jbt_pkg::MODE_IDLE))
   `JBT_ASSERT_NOW(a_offset_bounded, clock, reset,
      1'b1, (32'(off_ff) <= jbt_pkg::MAX_BUFFER))

endmodule
`default_nettype wire
